// ----- rtl/core/r2l_pkg.sv -----
// r2l_pkg: constants, types and the sRGB linearization table for rgb_to_lab.
// No dependencies; used by the top level (rgb_to_lab).
`default_nettype none
package r2l_pkg;

  localparam int unsigned MatQ16 [3][3] = '{
    '{28435, 24657, 12446},
    '{13933, 46871, 4732},
    '{1162, 7175, 57210}
  };
  localparam logic [24:0] FThresh = 25'd148579;
  localparam logic [20:0] FOffset = 21'd144631;
  localparam logic [24:0] Recip125 = 25'd17179870;

  typedef logic [15:0] lin_tbl_t [256];

  typedef struct packed {
    logic [60:0] tgt;
    logic [20:0] rt;
    logic [41:0] sq;
    logic [62:0] cb;
    logic        lo_sel;
    logic [30:0] lnum;
    logic [20:0] flin;
  } cr_ch_t;

  typedef struct packed {
    cr_ch_t [2:0] ch;
  } cr_t;

  function automatic longint unsigned pow5_q30(longint unsigned r);
    longint unsigned p;
    p = r;
    for (int k = 0; k < 4; k++) p = (p * r) >> 30;
    return p;
  endfunction

  function automatic logic [15:0] lin_calc(int unsigned c);
    longint unsigned v, v2, lo, hi, mid, lin;
    if (c <= 10) return 16'((longint'(c) * 6553600 + 164730) / 329460);
    v   = (((longint'(40 * c + 561)) << 30) + 5380) / 10761;
    v2  = (v * v + (64'd1 << 29)) >> 30;
    lo  = 0;
    hi  = 64'd1 << 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (pow5_q30(mid) <= v2) lo = mid;
      else hi = mid - 1;
    end
    lin = (v2 * lo + (64'd1 << 29)) >> 30;
    lin = (lin + 8192) >> 14;
    return (lin > 65535) ? 16'hFFFF : 16'(lin);
  endfunction

  function automatic lin_tbl_t build_lin();
    lin_tbl_t t;
    for (int c = 0; c < 256; c++) t[c] = lin_calc(c);
    return t;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/r2l_pix_if.sv -----
// r2l_pix_if: valid/ready channel carrying one 8-bit sRGB pixel per beat.
// No dependencies.
`default_nettype none
interface r2l_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/r2l_lab_if.sv -----
// r2l_lab_if: valid/ready channel carrying one Q8.8 L*a*b* result per beat.
// No dependencies.
`default_nettype none
interface r2l_lab_if;
  logic               valid;
  logic               ready;
  logic        [14:0] lightness;
  logic signed [15:0] green_red;
  logic signed [15:0] blue_yellow;
  modport source (output valid, lightness, green_red, blue_yellow, input ready);
  modport sink (input valid, lightness, green_red, blue_yellow, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/rgb_to_lab.sv -----
// rgb_to_lab: sRGB (8 bits per channel) to CIE L*a*b* D65, Q8.8 outputs.
// Depends on r2l_pkg, r2l_pix_if and r2l_lab_if.
//
// Usage:
//   in_pix  - sink channel, one pixel (red, green, blue) per beat.
//   out_lab - source channel, one result (lightness, green_red, blue_yellow)
//             per beat, in input order.
//   An accepted input beat passes through 27 register stages before it
//   reaches out_lab.valid. Throughput is one pixel per cycle while nothing
//   stalls: every stage is a register with its own valid bit, and the 21-bit
//   cube root takes one bit per stage over 21 stages.
//   Reset (rst_n low, synchronous) empties the pipeline; no sweep follows,
//   and in_pix.ready is high in the first cycle after reset.
//   When the receiver holds out_lab.ready low, the result holds in the output
//   register; earlier stages fill their bubbles and in_pix.ready drops only
//   once every stage holds a beat. Nothing is lost or repeated.
`default_nettype none
module rgb_to_lab (
  input  wire         clk,
  input  wire         rst_n,
  r2l_pix_if.sink     in_pix,
  r2l_lab_if.source   out_lab
);

  localparam int RootN = 22;
  localparam int RootS = 3;
  localparam int FS    = RootS + RootN;
  localparam int NS    = FS + 2;
  localparam r2l_pkg::lin_tbl_t LinTbl = r2l_pkg::build_lin();

  logic [NS-1:0] vld_r;
  logic [NS:0]   adv;

  always_comb begin
    adv[NS] = out_lab.ready;
    for (int k = NS - 1; k >= 0; k--) adv[k] = !vld_r[k] || adv[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_pix.valid;
      for (int k = 1; k < NS; k++)
        if (adv[k]) vld_r[k] <= vld_r[k-1];
    end
  end

  assign in_pix.ready  = adv[0];
  assign out_lab.valid = vld_r[NS-1];

  // linearize
  logic [15:0] lin_r [3];
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      lin_r[0] <= LinTbl[in_pix.red];
      lin_r[1] <= LinTbl[in_pix.green];
      lin_r[2] <= LinTbl[in_pix.blue];
    end
  end

  // matrix products
  logic [31:0] prod_r [3][3];
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          prod_r[i][j] <= 32'(lin_r[j]) * 32'(r2l_pkg::MatQ16[i][j]);
    end
  end

  // sum and round to Q24
  logic [24:0] t_r [3];
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int i = 0; i < 3; i++)
        t_r[i] <= 25'((34'(prod_r[i][0]) + 34'(prod_r[i][1]) + 34'(prod_r[i][2])
                       + 34'd128) >> 8);
    end
  end

  // cube root, one result bit per stage
  r2l_pkg::cr_t cr_r [RootN];

  always_ff @(posedge clk) begin
    if (adv[RootS]) begin
      for (int c = 0; c < 3; c++) begin
        cr_r[0].ch[c].tgt    <= {t_r[c], 36'd0};
        cr_r[0].ch[c].rt     <= '0;
        cr_r[0].ch[c].sq     <= '0;
        cr_r[0].ch[c].cb     <= '0;
        cr_r[0].ch[c].lo_sel <= (t_r[c] <= r2l_pkg::FThresh);
        cr_r[0].ch[c].lnum   <= 31'(38'(t_r[c]) * 38'd7787 + 38'd8000);
        cr_r[0].ch[c].flin   <= '0;
      end
    end
  end

  for (genvar j = 1; j < RootN; j++) begin : g_root
    localparam int K = RootN - 1 - j;
    r2l_pkg::cr_t nxt;
    always_comb begin
      logic [63:0] y3;
      logic [48:0] qp;
      nxt = cr_r[j-1];
      for (int c = 0; c < 3; c++) begin
        y3 = 64'(cr_r[j-1].ch[c].cb)
           + ((64'(cr_r[j-1].ch[c].sq) + (64'(cr_r[j-1].ch[c].sq) << 1)) << K)
           + ((64'(cr_r[j-1].ch[c].rt) + (64'(cr_r[j-1].ch[c].rt) << 1)) << (2 * K))
           + (64'd1 << (3 * K));
        if (y3 <= 64'(cr_r[j-1].ch[c].tgt)) begin
          nxt.ch[c].rt = cr_r[j-1].ch[c].rt | (21'd1 << K);
          nxt.ch[c].sq = cr_r[j-1].ch[c].sq + (42'(cr_r[j-1].ch[c].rt) << (K + 1))
                       + (42'd1 << (2 * K));
          nxt.ch[c].cb = y3[62:0];
        end
        qp = 49'(cr_r[j-1].ch[c].lnum[30:7]) * 49'(r2l_pkg::Recip125);
        if (j == 1) nxt.ch[c].flin = 21'(qp[48:31]) + r2l_pkg::FOffset;
      end
    end
    always_ff @(posedge clk) begin
      if (adv[RootS+j]) cr_r[j] <= nxt;
    end
  end

  // scale for L, a, b
  logic        [27:0] lp_r;
  logic signed [31:0] ap_r;
  logic signed [31:0] bp_r;
  logic [20:0] f_v [3];
  always_comb begin
    for (int c = 0; c < 3; c++)
      f_v[c] = cr_r[RootN-1].ch[c].lo_sel ? cr_r[RootN-1].ch[c].flin
                                          : cr_r[RootN-1].ch[c].rt;
  end

  always_ff @(posedge clk) begin
    if (adv[FS]) begin
      lp_r <= 28'(f_v[1]) * 28'd116;
      ap_r <= (signed'(32'(f_v[0])) - signed'(32'(f_v[1]))) * 32'sd500;
      bp_r <= (signed'(32'(f_v[1])) - signed'(32'(f_v[2]))) * 32'sd200;
    end
  end

  // round, clamp and hold for the receiver
  logic signed [19:0] l_v;
  logic signed [19:0] a_v;
  logic signed [19:0] b_v;
  logic        [14:0] l_r;
  logic signed [15:0] a_r;
  logic signed [15:0] b_r;
  always_comb begin
    l_v = 20'(signed'(29'((29'(lp_r) + 29'd2048) >> 12)) - 29'sd4096);
    a_v = 20'((ap_r + 32'sd2048) >>> 12);
    b_v = 20'((bp_r + 32'sd2048) >>> 12);
  end

  always_ff @(posedge clk) begin
    if (adv[FS+1]) begin
      l_r <= (l_v < 0) ? 15'd0 : (l_v > 20'sd25600) ? 15'd25600 : l_v[14:0];
      a_r <= (a_v < -20'sd32768) ? -16'sd32768 : (a_v > 20'sd32767) ? 16'sd32767 : a_v[15:0];
      b_r <= (b_v < -20'sd32768) ? -16'sd32768 : (b_v > 20'sd32767) ? 16'sd32767 : b_v[15:0];
    end
  end

  assign out_lab.lightness   = l_r;
  assign out_lab.green_red   = a_r;
  assign out_lab.blue_yellow = b_r;

`ifndef SYNTH
  a_light_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_lab.valid |-> out_lab.lightness <= 15'd25600)
    else $error("lightness above 100");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_lab.ready |-> in_pix.ready)
    else $error("input stalled while output drains");

  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[FS-1] |-> (64'(cr_r[RootN-1].ch[0].cb) <= 64'(cr_r[RootN-1].ch[0].tgt))
                 && (64'(cr_r[RootN-1].ch[1].cb) <= 64'(cr_r[RootN-1].ch[1].tgt))
                 && (64'(cr_r[RootN-1].ch[2].cb) <= 64'(cr_r[RootN-1].ch[2].tgt)))
    else $error("cube root overshoot");
`endif

endmodule
`default_nettype wire
